// ----- hw/rtl/sgd_pkg.sv -----
// ----------------------------------------------------------------------------
// sgd_pkg: shared constants and types for the Sobel gradient/direction block
// Line geometry, direction thresholds and the front-to-back request type.
// ----------------------------------------------------------------------------
package sgd_pkg;

	localparam int LineWidth = 2048;
	localparam int ColW      = $clog2(LineWidth + 1);
	localparam int AddrW     = $clog2(LineWidth);

	localparam logic signed [15:0] QNegHi = -16'sd618;
	localparam logic signed [15:0] QNegLo = -16'sd106;
	localparam logic signed [15:0] QPosLo = 16'sd106;
	localparam logic signed [15:0] QPosHi = 16'sd618;
	localparam logic [8:0] MagMax = 9'd255;

	localparam logic [1:0] DirFlat  = 2'd0;
	localparam logic [1:0] DirPos   = 2'd1;
	localparam logic [1:0] DirSteep = 2'd2;
	localparam logic [1:0] DirNeg   = 2'd3;

	// Request handed from the front end to the compute back end.
	typedef struct packed {
		logic [31:0]     word;
		logic            compute;
		logic signed [11:0] gx;
		logic signed [11:0] gy;
		logic [1:0]      side;
	} sgd_req_t;

endpackage

// ----- hw/rtl/sobel_gradient_direction.sv -----
// ----------------------------------------------------------------------------
// sobel_gradient_direction: Sobel edge magnitude and direction over a stream
// Front end buffers lines and sums gradients; back end forms the result.
// ----------------------------------------------------------------------------
//  channel | signals                                     | handshake
//  in      | pixel_word, frame_start, line_end           | in_valid / in_stall
//  out     | result_word, frame_start_out, line_end_out  | out_valid / out_stall
//
// The front end takes one pixel at a time through four steps (accept, line
// RAM read, gradient sum, queue push) and takes no new pixel until the push.
// Results pass through stage 1 and the output register of the back end.
// arst_n clears counters, window and queue; line RAM contents are undefined.
// A stalled output fills the back end, then the queue, then stalls input.
module sobel_gradient_direction import sgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pixel_word,
	input  logic        frame_start,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_word,
	output logic        frame_start_out,
	output logic        line_end_out
);

	sgd_req_t f_req, b_req;
	logic     f_valid, f_stall, b_valid, b_stall;

	sgd_front u_front (
		.clk, .arst_n, .pixel_word, .frame_start, .line_end,
		.in_valid, .in_stall,
		.req_valid (f_valid), .req (f_req), .req_stall (f_stall)
	);

	sgd_queue u_queue (
		.clk, .arst_n,
		.wr_valid (f_valid), .wr_stall (f_stall), .wr_data (f_req),
		.rd_valid (b_valid), .rd_stall (b_stall), .rd_data (b_req)
	);

	sgd_back u_back (
		.clk, .arst_n,
		.req_valid (b_valid), .req_stall (b_stall), .req (b_req),
		.valid (out_valid), .stall (out_stall),
		.result_word, .frame_start_out, .line_end_out
	);

endmodule

// ----- hw/rtl/sgd_ram.sv -----
// ----------------------------------------------------------------------------
// sgd_ram: generic single-port-write, single-port-read RAM
// Registered read data; no reset on contents.
// ----------------------------------------------------------------------------
module sgd_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/sgd_front.sv -----
// ----------------------------------------------------------------------------
// sgd_front: line buffers, window and gradient sums
// Accepts a pixel, reads the two older lines, forms gx and gy.
// ----------------------------------------------------------------------------
module sgd_front import sgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] pixel_word,
	input  logic        frame_start,
	input  logic        line_end,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        req_valid,
	output sgd_req_t    req,
	input  logic        req_stall
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_PUSH} state_t;

	state_t          state_q;
	logic [31:0]     word_q;
	logic [ColW-1:0] col_q;
	logic [1:0]      seen_q, slot_q, side_q;
	logic [7:0]      win_q [3][3];
	logic            inrange_q;
	logic            calc_q;
	sgd_req_t        req_q;

	logic [ColW-1:0] col_eff;
	logic [1:0]      seen_eff;
	logic            inrange;
	logic [1:0]      src0, src1;
	logic [1:0]      rsel_q;
	logic [7:0]      rd0, rd1, rd2;
	logic [7:0]      ram_rd [3];
	logic [1:0]      upcount;

	assign in_stall  = (state_q != S_IDLE);
	assign req_valid = (state_q == S_PUSH);
	assign req       = req_q;

	assign col_eff  = frame_start ? '0 : col_q;
	assign seen_eff = frame_start ? 2'd0 : seen_q;
	assign inrange  = (col_eff < ColW'(LineWidth));
	assign src0 = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
	assign src1 = (src0 == 2'd2) ? 2'd0 : src0 + 2'd1;

	// Three line RAMs; one written per accepted in-range pixel, older ones read
	genvar g;
	for (g = 0; g < 3; g++) begin : g_line
		sgd_ram #(.Width(8), .Depth(LineWidth)) u_ram (
			.clk   (clk),
			.we    (in_valid && !in_stall && inrange && slot_q == 2'(g)),
			.waddr (col_eff[AddrW-1:0]),
			.wdata (pixel_word[7:0]),
			.re    (in_valid && !in_stall),
			.raddr (col_eff[AddrW-1:0]),
			.rdata (ram_rd[g])
		);
	end

	// Pick read data of the two older lines; source slots saved at accept
	always_comb begin
		rd0 = ram_rd[0];
		rd1 = ram_rd[0];
		case (rsel_q)
			2'd1:    rd0 = ram_rd[1];
			2'd2:    rd0 = ram_rd[2];
			default: rd0 = ram_rd[0];
		endcase
		case ((rsel_q == 2'd2) ? 2'd0 : rsel_q + 2'd1)
			2'd1:    rd1 = ram_rd[1];
			2'd2:    rd1 = ram_rd[2];
			default: rd1 = ram_rd[0];
		endcase
		rd2 = word_q[7:0];
	end

	// Gradient sums on the shifted window
	logic signed [11:0] gx_c, gy_c;
	always_comb begin
		gx_c = (12'(win_q[0][2]) + {3'b0, win_q[1][2], 1'b0} + 12'(win_q[2][2]))
		     - (12'(win_q[0][0]) + {3'b0, win_q[1][0], 1'b0} + 12'(win_q[2][0]));
		gy_c = (12'(win_q[2][0]) + {3'b0, win_q[2][1], 1'b0} + 12'(win_q[2][2]))
		     - (12'(win_q[0][0]) + {3'b0, win_q[0][1], 1'b0} + 12'(win_q[0][2]));
	end

	assign upcount = (seen_eff == 2'd2) ? 2'd2 : seen_eff + 2'd1;

	// Sequence: accept, read lines and shift window, sum, push request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			seen_q  <= '0;
			slot_q  <= '0;
			side_q  <= '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						word_q    <= pixel_word;
						inrange_q <= inrange;
						calc_q    <= (seen_eff == 2'd2);
						rsel_q    <= src0;
						req_q.side <= side_q;
						side_q    <= {line_end, frame_start};
						if (line_end) begin
							col_q  <= '0;
							seen_q <= upcount;
							slot_q <= src0;
						end else begin
							col_q  <= inrange ? col_eff + ColW'(1) : col_eff;
							seen_q <= seen_eff;
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					for (int r = 0; r < 3; r++) begin
						win_q[r][0] <= win_q[r][1];
						win_q[r][1] <= win_q[r][2];
					end
					win_q[0][2] <= inrange_q ? rd0 : 8'd0;
					win_q[1][2] <= inrange_q ? rd1 : 8'd0;
					win_q[2][2] <= rd2;
					state_q <= S_CALC;
				end
				S_CALC: begin
					req_q.word    <= word_q;
					req_q.compute <= calc_q;
					req_q.gx      <= gx_c;
					req_q.gy      <= gy_c;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!req_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/sgd_queue.sv -----
// ----------------------------------------------------------------------------
// sgd_queue: two-entry request queue between front and back end
// Lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module sgd_queue import sgd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_stall,
	input  sgd_req_t wr_data,
	output logic     rd_valid,
	input  logic     rd_stall,
	output sgd_req_t rd_data
);

	sgd_req_t   ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = ent_q[rp_q];
	assign push = wr_valid && !wr_stall;
	assign pop  = rd_valid && !rd_stall;

	// Store entry
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- hw/rtl/sgd_back.sv -----
// ----------------------------------------------------------------------------
// sgd_back: magnitude and direction from gx and gy
// Classifies (gy*256)/gx by cross-multiplying against the thresholds.
// ----------------------------------------------------------------------------
module sgd_back import sgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  sgd_req_t    req,
	output logic        valid,
	input  logic        stall,
	output logic [31:0] result_word,
	output logic        frame_start_out,
	output logic        line_end_out
);

	// Stage 1: magnitude, and |q| class via |gy|*256 vs T*|gx| (+ sign)
	logic        v_s1;
	logic [31:0] word_s1;
	logic        comp_s1;
	logic [1:0]  side_s1;
	logic [7:0]  mag_s1;
	logic [1:0]  dir_s1;
	logic        out_v_q;
	logic [31:0] res_q;
	logic [1:0]  side_q;

	logic [11:0] ax, ay;
	logic [12:0] msum;
	logic [19:0] num;
	logic        neg;
	logic [21:0] t_lo, t_hi;
	logic        le_lo, ge_hi;
	logic [1:0]  dir_c;
	logic        adv;

	assign ax   = req.gx[11] ? 12'(-req.gx) : req.gx;
	assign ay   = req.gy[11] ? 12'(-req.gy) : req.gy;
	assign msum = 13'(ax) + 13'(ay);
	assign num  = {ay, 8'd0};
	assign neg  = req.gx[11] ^ req.gy[11];
	// Bounds are one step tighter on the negative side: -106 is inside the
	// negative band, -618 in the steep band; 106 and 618 inside the flat and positive bands.
	// Truncated |q| <= T  <=>  |num| < (T+1)*|ax|
	assign t_lo = 22'(ax) * (neg ? 22'(-QNegLo) : 22'(QPosLo + 16'sd1));
	assign t_hi = 22'(ax) * (neg ? 22'(-QNegHi) : 22'(QPosHi + 16'sd1));
	assign le_lo = 22'(num) < t_lo;
	assign ge_hi = 22'(num) >= t_hi;

	always_comb begin
		if (req.gx == 12'sd0) begin
			dir_c = DirSteep;
		end else if (le_lo) begin
			dir_c = DirFlat;
		end else if (ge_hi) begin
			dir_c = DirSteep;
		end else if (neg) begin
			dir_c = DirNeg;
		end else begin
			dir_c = DirPos;
		end
	end

	assign adv = !out_v_q || !stall;
	assign req_stall = v_s1 && !adv;

	// Register stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			word_s1 <= req.word;
			comp_s1 <= req.compute;
			side_s1 <= req.side;
			mag_s1  <= (msum > 13'(MagMax)) ? 8'd255 : msum[7:0];
			dir_s1  <= dir_c;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			res_q  <= comp_s1 ? {6'd0, dir_s1, mag_s1, mag_s1, mag_s1} : word_s1;
			side_q <= side_s1;
		end
	end

	assign valid           = out_v_q;
	assign result_word     = res_q;
	assign frame_start_out = side_q[0];
	assign line_end_out    = side_q[1];

endmodule

// ----- dv/sgd_checker.sv -----
// ----------------------------------------------------------------------------
// sgd_checker: pixel-level predictor and result scoreboard for the Sobel block
// Watches both channels, predicts each result from the accepted pixel
// requests and compares the results field by field in arrival order.
// ----------------------------------------------------------------------------
module sgd_checker import sgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] pixel_word,
	input  logic        frame_start,
	input  logic        line_end,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] result_word,
	input  logic        frame_start_out,
	input  logic        line_end_out,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] word;
		logic        fs;
		logic        le;
	} edge_result_t;

	edge_result_t expected_results[$];

	// predictor state
	logic [7:0] lines_mem [0:3*LineWidth-1];
	logic [7:0] win [0:2][0:2];
	int         col_pos;
	int         full_lines;
	int         cur_slot;
	logic [1:0] last_side;

	initial begin
		foreach (lines_mem[i]) lines_mem[i] = 8'd0;
		foreach (win[r, c]) win[r][c] = 8'd0;
		col_pos    = 0;
		full_lines = 0;
		cur_slot   = 0;
		last_side  = 2'b00;
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic [1:0] direction_of(int gx, int gy);
		int q;
		if (gx == 0) begin
			return DirSteep;
		end
		q = (gy * 256) / gx;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		if (q > int'(QNegHi) && q <= int'(QNegLo)) return DirNeg;
		if (q > int'(QNegLo) && q <= int'(QPosLo)) return DirFlat;
		if (q > int'(QPosLo) && q <= int'(QPosHi)) return DirPos;
		return DirSteep;
	endfunction

	// advance the line buffers and window by one pixel, queue the result
	task automatic predict_pixel(logic [31:0] word, logic fs, logic le);
		edge_result_t res;
		logic [7:0]   gray;
		int           src;
		int           gx;
		int           gy;
		int           mag;
		gray = word[7:0];
		if (fs) begin
			col_pos    = 0;
			full_lines = 0;
		end
		if (col_pos < LineWidth) lines_mem[cur_slot*LineWidth + col_pos] = gray;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		for (int r = 0; r < 2; r++) begin
			src = (cur_slot + r + 1) % 3;
			win[r][2] = (col_pos < LineWidth) ? lines_mem[src*LineWidth + col_pos] : 8'd0;
		end
		win[2][2] = gray;
		if (full_lines >= 2) begin
			gx = (int'(win[0][2]) + 2*int'(win[1][2]) + int'(win[2][2]))
			   - (int'(win[0][0]) + 2*int'(win[1][0]) + int'(win[2][0]));
			gy = (int'(win[2][0]) + 2*int'(win[2][1]) + int'(win[2][2]))
			   - (int'(win[0][0]) + 2*int'(win[0][1]) + int'(win[0][2]));
			mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			if (mag > int'(MagMax)) mag = int'(MagMax);
			res.word = {6'd0, direction_of(gx, gy), {3{mag[7:0]}}};
		end else begin
			res.word = word;
		end
		res.fs = last_side[0];
		res.le = last_side[1];
		expected_results.push_back(res);
		last_side = {le, fs};
		if (le) begin
			col_pos = 0;
			if (full_lines < 2) full_lines++;
			cur_slot = (cur_slot + 1) % 3;
		end else if (col_pos < LineWidth) begin
			col_pos++;
		end
	endtask

	// predict on accepted requests, then compare accepted results
	always @(posedge clk) begin
		edge_result_t exp_res;
		if (arst_n) begin
			if (in_valid && !in_stall) predict_pixel(pixel_word, frame_start, line_end);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: word %h fs %b le %b",
							result_word, frame_start_out, line_end_out);
				end else begin
					exp_res = expected_results.pop_front();
					if (result_word !== exp_res.word || frame_start_out !== exp_res.fs
							|| line_end_out !== exp_res.le) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %h/%b/%b got %h/%b/%b",
								exp_res.word, exp_res.fs, exp_res.le,
								result_word, frame_start_out, line_end_out);
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for sobel_gradient_direction
// Fills the front of every line buffer, runs a directed edge pattern, then
// random frames with random idle and stall bursts; the checker scores them.
// ----------------------------------------------------------------------------
module testbench import sgd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 2000000;
	localparam int FillWidth  = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] pixel_word = 32'd0;
	logic        frame_start = 1'b0;
	logic        line_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_word;
	logic        frame_start_out;
	logic        line_end_out;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          stall_left = 0;
	bit          quiet = 1'b0;
	int          random_sent = 0;

	sobel_gradient_direction uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_word(pixel_word), .frame_start(frame_start), .line_end(line_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_word(result_word), .frame_start_out(frame_start_out),
		.line_end_out(line_end_out)
	);

	sgd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_word(pixel_word), .frame_start(frame_start), .line_end(line_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_word(result_word), .frame_start_out(frame_start_out),
		.line_end_out(line_end_out),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// stall the output in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// drive one pixel request and hold it until accepted
	task automatic send(logic [31:0] w, logic fs, logic le);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_word  <= w;
		frame_start <= fs;
		line_end    <= le;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_gray(int mode, int c);
		case (mode)
			0: return 8'($urandom);
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'(c * 9 + $urandom_range(0, 3));
		endcase
	endfunction

	initial begin
		int lines;
		int len;
		int mode;
		int col_now;
		logic fs;
		logic le;
		logic [31:0] rw;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write the first columns of every line buffer; restart the frame on
		// each line so that nothing is computed from unwritten entries
		for (int ln = 0; ln < 3; ln++)
			for (int c = 0; c < FillWidth; c++)
				send($urandom, c == 0, c == FillWidth - 1);

		// directed: a flat dark line, then a vertical step and
		// a ramp; upper bytes at both extremes
		for (int ln = 0; ln < 3; ln++)
			for (int c = 0; c < 8; c++) begin
				case (ln)
					0: len = 0;
					1: len = (c < 4) ? 0 : 255;
					default: len = 255 - c * 36;
				endcase
				send({(c % 2) ? 24'hFFFFFF : 24'h000000, 8'(len)}, ln == 0 && c == 0, c == 7);
			end

		// random frames, mostly well formed with some noise; columns stay
		// inside the filled part of the line buffers
		col_now = 0;
		while (random_sent < 1200) begin
			lines = $urandom_range(3, 6);
			for (int ln = 0; ln < lines; ln++) begin
				len = $urandom_range(1, FillWidth);
				mode = $urandom_range(0, 2);
				for (int c = 0; c < len; c++) begin
					fs = (ln == 0 && c == 0);
					le = (c == len - 1);
					if ($urandom_range(0, 39) == 0) fs = ~fs;
					if ($urandom_range(0, 39) == 0) le = ~le;
					if (fs) col_now = 0;
					if (col_now >= FillWidth - 1) le = 1'b1;
					quiet = (random_sent > 1000);
					rw = $urandom;
					send({rw[31:8], pick_gray(mode, c)}, fs, le);
					random_sent++;
					col_now = le ? 0 : col_now + 1;
				end
			end
		end

		// drain
		quiet = 1'b1;
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
